FILE: design/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared constants and types of the pooled free-list block allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    // Default geometry
    localparam int unsigned BLOCKS_IN_POOL_DEF = 64;
    localparam int unsigned MAX_POOLS_DEF      = 16;

    // Fixed port field widths
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LIVE_W   = 11;
    localparam int unsigned POOLS_W  = 5;

    // Request opcodes
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

endpackage

FILE: design/pooled_free_list_allocator.sv
// ----------------------------------------------------------------------------
// pooled_free_list_allocator
// Fixed-size block allocator with a LIFO free list and lazily opened pools.
// ----------------------------------------------------------------------------
// A request is taken on start while busy is low; busy is high for one cycle
// while the link and mark memories return the entry for the list head
// (allocate) or the named block (free), and o_done pulses for one cycle with
// the result in the cycle after that. A new request may be issued in the cycle
// o_done is high. Results are not held: sample them when o_done is high. No
// clearing pass follows reset; the block is ready at once.
module pooled_free_list_allocator
    import pfla_pkg::*;
#(
    parameter int unsigned BLOCKS_IN_POOL = BLOCKS_IN_POOL_DEF,
    parameter int unsigned MAX_POOLS      = MAX_POOLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [INDEX_W-1:0]  i_block_index,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_granted_index,
    output logic [LIVE_W-1:0]   o_live_count,
    output logic [POOLS_W-1:0]  o_pools_in_use
);

    localparam int unsigned TOTAL  = BLOCKS_IN_POOL * MAX_POOLS;
    localparam int unsigned IDX_W  = (TOTAL > 2) ? $clog2(TOTAL) : 1;
    localparam int unsigned CNT_W  = $clog2(TOTAL + 1);
    localparam int unsigned WIDE_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
    localparam int unsigned OFS_W  = $clog2(BLOCKS_IN_POOL);
    localparam int unsigned PL_W   = $clog2(MAX_POOLS + 1);
    localparam int unsigned PWID_W = (PL_W > POOLS_W) ? PL_W : POOLS_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state               r_state;
    logic                 r_opcode;
    logic [INDEX_W-1:0]   r_idx;
    logic [IDX_W-1:0]     r_head;
    logic                 r_head_valid;
    logic [CNT_W-1:0]     r_fresh;
    logic [CNT_W-1:0]     r_total;
    logic [OFS_W-1:0]     r_pool_ofs;
    logic [PL_W-1:0]      r_pools;
    logic [IDX_W-1:0]     r_link_rd;
    logic                 r_mark_rd;

    logic [IDX_W-1:0]     link_mem [TOTAL];
    logic                 mark_mem [TOTAL];

    // Datapath of the execute cycle
    logic [WIDE_W-1:0]    w_in_wide;
    logic [WIDE_W-1:0]    w_req_wide;
    logic [WIDE_W-1:0]    w_fresh_wide;
    logic [IDX_W-1:0]     w_in_addr;
    logic [IDX_W-1:0]     w_req_addr;
    logic [CNT_W-1:0]     w_total_inc;
    logic                 w_pop;
    logic                 w_fresh_ok;
    logic                 w_free_ok;
    logic [IDX_W-1:0]     w_granted;
    logic [WIDE_W-1:0]    w_granted_wide;
    logic [WIDE_W-1:0]    n_live_wide;
    logic [PWID_W-1:0]    n_pools_wide;
    t_status              n_status;
    logic [CNT_W-1:0]     n_total;
    logic [PL_W-1:0]      n_pools;

    assign w_in_wide    = WIDE_W'(i_block_index);
    assign w_req_wide   = WIDE_W'(r_idx);
    assign w_fresh_wide = WIDE_W'(r_fresh);
    assign w_in_addr    = w_in_wide[IDX_W-1:0];
    assign w_req_addr   = w_req_wide[IDX_W-1:0];
    assign w_total_inc  = r_total + CNT_W'(1);

    always_comb begin
        w_pop      = 1'b0;
        w_fresh_ok = 1'b0;
        w_free_ok  = 1'b0;
        w_granted  = '0;
        n_status   = ST_OK;
        n_total    = r_total;
        n_pools    = r_pools;
        unique case (t_opcode'(r_opcode))
            OP_ALLOC: begin
                priority if (r_head_valid) begin
                    w_pop     = 1'b1;
                    w_granted = r_head;
                    n_total   = w_total_inc;
                end else if (r_fresh < CNT_W'(TOTAL)) begin
                    w_fresh_ok = 1'b1;
                    w_granted  = r_fresh[IDX_W-1:0];
                    n_total    = w_total_inc;
                    if (r_pool_ofs == '0) begin
                        n_pools = r_pools + PL_W'(1);
                    end
                end else begin
                    n_status = ST_OOM;
                end
            end
            OP_FREE: begin
                if (w_req_wide >= w_fresh_wide || !r_mark_rd) begin
                    n_status = ST_BADFREE;
                end else begin
                    w_free_ok = 1'b1;
                    n_total   = r_total - CNT_W'(1);
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    assign w_granted_wide = WIDE_W'(w_granted);
    assign n_live_wide    = WIDE_W'(n_total);
    assign n_pools_wide   = PWID_W'(n_pools);

    // Memories: read in the idle cycle, write in the execute cycle only
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_link_rd <= link_mem[r_head];
            r_mark_rd <= mark_mem[w_in_addr];
        end
        if (r_state == S_EXEC) begin
            if (w_pop) begin
                mark_mem[r_head] <= 1'b1;
            end else if (w_fresh_ok) begin
                mark_mem[r_fresh[IDX_W-1:0]] <= 1'b1;
            end else if (w_free_ok) begin
                mark_mem[w_req_addr] <= 1'b0;
                link_mem[w_req_addr] <= r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_fresh      <= '0;
            r_total      <= '0;
            r_pool_ofs   <= '0;
            r_pools      <= '0;
            o_done       <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_opcode <= i_opcode;
                        r_idx    <= i_block_index;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state         <= S_IDLE;
                    o_done          <= 1'b1;
                    o_status        <= n_status;
                    o_granted_index <= w_granted_wide[INDEX_W-1:0];
                    o_live_count    <= n_live_wide[LIVE_W-1:0];
                    o_pools_in_use  <= n_pools_wide[POOLS_W-1:0];
                    r_total         <= n_total;
                    r_pools         <= n_pools;
                    if (w_pop) begin
                        // advance the head; the list ends when no freed block remains
                        r_head       <= r_link_rd;
                        r_head_valid <= (r_fresh != w_total_inc);
                    end else if (w_fresh_ok) begin
                        r_fresh    <= r_fresh + CNT_W'(1);
                        r_pool_ofs <= (r_pool_ofs == OFS_W'(BLOCKS_IN_POOL - 1))
                                      ? '0 : r_pool_ofs + OFS_W'(1);
                    end else if (w_free_ok) begin
                        r_head       <= w_req_addr;
                        r_head_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

    // The free list is non-empty exactly when some used block is not live
    a_head_valid_tracks_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_valid == (r_fresh != r_total))
        else $error("free list valid flag disagrees with block counts");

    a_live_not_above_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_fresh)
        else $error("live count exceeds blocks ever used");

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without an executed request");

    a_oom_only_when_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OOM) |-> (r_fresh == CNT_W'(TOTAL) && !r_head_valid))
        else $error("out of memory reported while blocks remain");

    a_pools_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pools <= PL_W'(MAX_POOLS))
        else $error("pool count beyond maximum");

endmodule
